// File: hw/rtl/bdq_pkg.sv
// Shared types, operation codes and status codes for the bounded deque with search.
package bdq_pkg;

    localparam int OP_W    = 3;
    localparam int VALUE_W = 32;
    localparam int ST_W    = 2;
    localparam int POS_W   = 7;

    localparam int DEPTH_DEF = 64;

    typedef logic [OP_W-1:0]           t_op;
    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [ST_W-1:0]           t_status;
    typedef logic [POS_W-1:0]          t_pos;

    localparam t_op OP_PUSH_FRONT = 3'd0;
    localparam t_op OP_PUSH_BACK  = 3'd1;
    localparam t_op OP_POP_FRONT  = 3'd2;
    localparam t_op OP_POP_BACK   = 3'd3;
    localparam t_op OP_SEARCH     = 3'd4;
    localparam t_op OP_COUNT      = 3'd5;

    localparam t_status ST_DONE      = 2'd0;
    localparam t_status ST_EMPTY     = 2'd1;
    localparam t_status ST_FULL      = 2'd2;
    localparam t_status ST_NOT_FOUND = 2'd3;

endpackage

// File: hw/rtl/bdq_if.sv
// Request and response channel interfaces of the bounded deque with search.
interface bdq_req_if;
    logic            valid;
    logic            ready;
    bdq_pkg::t_op    op;
    bdq_pkg::t_value value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface bdq_rsp_if;
    logic             valid;
    logic             ready;
    bdq_pkg::t_status status;
    bdq_pkg::t_pos    position;
    bdq_pkg::t_pos    entry_count;

    modport source (output valid, output status, output position, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input position, input entry_count,
                    output ready);
endinterface

// File: hw/rtl/bdq_store.sv
// Entry memory: one write port and one read port with registered read data.
module bdq_store #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  bdq_pkg::t_value i_wdata,
    input  logic [AW-1:0]   i_raddr,
    output bdq_pkg::t_value o_rdata
);

    bdq_pkg::t_value r_mem [DEPTH];
    bdq_pkg::t_value r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/bounded_deque_with_search_unit.sv
// Top level of the bounded deque with search: ring pointers, sequencer and result register.
// Push, pop, count and unused codes: the result is registered and valid in the cycle after acceptance.
// Search: one memory read and compare per cycle from the front entry back, ending at the first
// match or at the last held entry; an empty store answers in the cycle after acceptance.
// One item is in work at a time; the next can be taken as early as the cycle in which the last result is taken.
// Synchronous active-low reset empties the deque; stored entries are not cleared.
module bounded_deque_with_search_unit #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bdq_req_if.sink   i_req,
    bdq_rsp_if.source o_rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = (CW > bdq_pkg::POS_W) ? CW : bdq_pkg::POS_W;

    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
    localparam logic [AW:0]   DEPTH_EXT = (AW + 1)'(DEPTH);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
        return (s == LAST_SLOT) ? '0 : s + 1'b1;
    endfunction

    function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] s);
        return (s == '0) ? LAST_SLOT : s - 1'b1;
    endfunction

    function automatic bdq_pkg::t_pos to_pos(input logic [CW-1:0] v);
        logic [WW-1:0] e;
        e = WW'(v);
        return e[bdq_pkg::POS_W-1:0];
    endfunction

    logic                r_state,     n_state;
    logic [AW-1:0]       r_front,     n_front;
    logic [CW-1:0]       r_count,     n_count;
    logic [AW-1:0]       r_rd_slot,   n_rd_slot;
    logic [CW-1:0]       r_idx,       n_idx;
    bdq_pkg::t_value     r_key,       n_key;
    logic                r_out_valid, n_out_valid;
    bdq_pkg::t_status    r_status,    n_status;
    bdq_pkg::t_pos       r_position,  n_position;
    bdq_pkg::t_pos       r_out_count, n_out_count;

    logic                accept;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [AW-1:0]       mem_raddr;
    bdq_pkg::t_value     mem_rdata;
    logic [AW:0]         back_sum;
    logic [AW-1:0]       back_slot;
    logic [AW-1:0]       front_dec;
    logic                is_full;
    logic                is_empty;

    assign i_req.ready = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign accept      = i_req.valid && i_req.ready;

    assign is_full   = (r_count == FULL_CNT);
    assign is_empty  = (r_count == '0);
    assign front_dec = slot_dec(r_front);
    assign back_sum  = (AW + 1)'(r_front) + (AW + 1)'(r_count[AW-1:0]);
    assign back_slot = (back_sum >= DEPTH_EXT) ? AW'(back_sum - DEPTH_EXT) : back_sum[AW-1:0];
    assign mem_raddr = (r_state == S_SCAN) ? r_rd_slot : r_front;

    bdq_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (i_req.value),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_count     = r_count;
        n_rd_slot   = r_rd_slot;
        n_idx       = r_idx;
        n_key       = r_key;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_position  = r_position;
        n_out_count = r_out_count;
        mem_we      = 1'b0;
        mem_waddr   = back_slot;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_out_valid = 1'b1;
                    n_status    = bdq_pkg::ST_DONE;
                    n_position  = '0;
                    case (i_req.op)
                        bdq_pkg::OP_PUSH_FRONT: begin
                            if (is_full) begin
                                n_status = bdq_pkg::ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = front_dec;
                                n_front   = front_dec;
                                n_count   = r_count + 1'b1;
                            end
                        end
                        bdq_pkg::OP_PUSH_BACK: begin
                            if (is_full) begin
                                n_status = bdq_pkg::ST_FULL;
                            end else begin
                                mem_we  = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        bdq_pkg::OP_POP_FRONT: begin
                            if (is_empty) begin
                                n_status = bdq_pkg::ST_EMPTY;
                            end else begin
                                n_front = slot_inc(r_front);
                                n_count = r_count - 1'b1;
                            end
                        end
                        bdq_pkg::OP_POP_BACK: begin
                            if (is_empty) begin
                                n_status = bdq_pkg::ST_EMPTY;
                            end else begin
                                n_count = r_count - 1'b1;
                            end
                        end
                        bdq_pkg::OP_SEARCH: begin
                            if (is_empty) begin
                                n_status = bdq_pkg::ST_NOT_FOUND;
                            end else begin
                                n_out_valid = 1'b0;
                                n_state     = S_SCAN;
                                n_key       = i_req.value;
                                n_rd_slot   = slot_inc(r_front);
                                n_idx       = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_out_count = to_pos(n_count);
                end
            end
            S_SCAN: begin
                if (mem_rdata == r_key) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_status    = bdq_pkg::ST_DONE;
                    n_position  = to_pos(r_idx + 1'b1);
                    n_out_count = to_pos(r_count);
                end else if (r_idx + 1'b1 == r_count) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_status    = bdq_pkg::ST_NOT_FOUND;
                    n_position  = '0;
                    n_out_count = to_pos(r_count);
                end else begin
                    n_idx     = r_idx + 1'b1;
                    n_rd_slot = slot_inc(r_rd_slot);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_slot   <= n_rd_slot;
        r_idx       <= n_idx;
        r_key       <= n_key;
        r_status    <= n_status;
        r_position  <= n_position;
        r_out_count <= n_out_count;
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.position    = r_position;
    assign o_rsp.entry_count = r_out_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count exceeds depth");

    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && is_full &&
        (i_req.op == bdq_pkg::OP_PUSH_FRONT || i_req.op == bdq_pkg::OP_PUSH_BACK)
        |=> r_out_valid && r_status == bdq_pkg::ST_FULL && $stable(r_count)
            && $stable(r_front))
        else $error("push on full store changed state or missed flag");

    a_scan_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> !r_out_valid && !i_req.ready)
        else $error("result pending or item taken during scan");

    a_scan_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_idx < r_count)
        else $error("scan index beyond held entries");

    a_scan_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |=> $stable(r_count) && $stable(r_front))
        else $error("deque pointers moved during scan");

endmodule

// File: bench/tb_top.sv
// Self-checking bench for the bounded deque with search: directed table, then random bursts.
`timescale 1ns / 100ps

module tb_top;

    localparam int           RING_DEPTH  = bdq_pkg::DEPTH_DEF;
    localparam int           ITEM_TARGET = 400;
    localparam int           DRAIN_WAIT  = RING_DEPTH + 8;
    localparam bdq_pkg::t_op OP_UNUSED_6 = 3'd6;
    localparam bdq_pkg::t_op OP_UNUSED_7 = 3'd7;

    typedef struct packed {
        bdq_pkg::t_status status;
        bdq_pkg::t_pos    position;
        bdq_pkg::t_pos    entry_count;
    } t_reply;

    typedef struct packed {
        bdq_pkg::t_op     op;
        bdq_pkg::t_value  value;
        bit               fixed;
        bdq_pkg::t_status status;
        bdq_pkg::t_pos    position;
        bdq_pkg::t_pos    entry_count;
    } t_dir_row;

    typedef enum {MODE_FILL, MODE_SEARCH, MODE_MIXED, MODE_DRAIN} t_mode;

    logic i_clk;
    logic i_rst_n;

    bdq_req_if req_ch ();
    bdq_rsp_if rsp_ch ();

    bounded_deque_with_search_unit #(.DEPTH(RING_DEPTH)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    bdq_pkg::t_value ring_mem [RING_DEPTH];
    logic [5:0] head_slot;
    logic [6:0] held;

    t_reply   pending_replies [$];
    t_dir_row dir_rows [25];
    int       mismatches;
    int       items_sent;
    bit       quiet;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 80);
    endfunction

    function automatic t_reply deque_apply(bdq_pkg::t_op op, bdq_pkg::t_value value);
        t_reply r;
        bit     found;
        r = '{status: bdq_pkg::ST_DONE, position: '0, entry_count: '0};
        case (op)
            bdq_pkg::OP_PUSH_FRONT: begin
                if (held >= RING_DEPTH) begin
                    r.status = bdq_pkg::ST_FULL;
                end else begin
                    head_slot = head_slot - 6'd1;
                    ring_mem[head_slot] = value;
                    held = held + 7'd1;
                end
            end
            bdq_pkg::OP_PUSH_BACK: begin
                if (held >= RING_DEPTH) begin
                    r.status = bdq_pkg::ST_FULL;
                end else begin
                    ring_mem[6'(head_slot + held[5:0])] = value;
                    held = held + 7'd1;
                end
            end
            bdq_pkg::OP_POP_FRONT: begin
                if (held == 0) begin
                    r.status = bdq_pkg::ST_EMPTY;
                end else begin
                    head_slot = head_slot + 6'd1;
                    held = held - 7'd1;
                end
            end
            bdq_pkg::OP_POP_BACK: begin
                if (held == 0) begin
                    r.status = bdq_pkg::ST_EMPTY;
                end else begin
                    held = held - 7'd1;
                end
            end
            bdq_pkg::OP_SEARCH: begin
                found = 1'b0;
                for (int i = 0; i < held && !found; i++) begin
                    if (ring_mem[6'(head_slot + i)] == value) begin
                        found = 1'b1;
                        r.position = bdq_pkg::t_pos'(i + 1);
                    end
                end
                if (!found) r.status = bdq_pkg::ST_NOT_FOUND;
            end
            default: ;
        endcase
        r.entry_count = held;
        return r;
    endfunction

    function automatic bdq_pkg::t_value pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return '0;
            3:       return -32'sd1;
            4, 5:    return bdq_pkg::t_value'($urandom_range(0, 7));
            default: return bdq_pkg::t_value'($urandom);
        endcase
    endfunction

    function automatic bdq_pkg::t_value pick_search_value();
        if (held != 0 && $urandom_range(0, 9) < 6)
            return ring_mem[6'(head_slot + $urandom_range(0, held - 1))];
        return pick_value();
    endfunction

    function automatic bdq_pkg::t_op pick_op(t_mode mode);
        int unsigned r;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_FILL: begin
                if (r < 42) return bdq_pkg::OP_PUSH_FRONT;
                if (r < 85) return bdq_pkg::OP_PUSH_BACK;
                if (r < 90) return bdq_pkg::OP_SEARCH;
                if (r < 95) return bdq_pkg::OP_COUNT;
                return (r < 98) ? bdq_pkg::OP_POP_FRONT : bdq_pkg::OP_POP_BACK;
            end
            MODE_DRAIN: begin
                if (r < 42) return bdq_pkg::OP_POP_FRONT;
                if (r < 85) return bdq_pkg::OP_POP_BACK;
                if (r < 93) return bdq_pkg::OP_SEARCH;
                if (r < 97) return bdq_pkg::OP_COUNT;
                return (r < 99) ? OP_UNUSED_6 : OP_UNUSED_7;
            end
            MODE_SEARCH: begin
                if (r < 70) return bdq_pkg::OP_SEARCH;
                if (r < 78) return bdq_pkg::OP_PUSH_FRONT;
                if (r < 85) return bdq_pkg::OP_PUSH_BACK;
                if (r < 90) return bdq_pkg::OP_POP_FRONT;
                if (r < 95) return bdq_pkg::OP_POP_BACK;
                return bdq_pkg::OP_COUNT;
            end
            default: return bdq_pkg::t_op'($urandom_range(0, 7));
        endcase
    endfunction

    task automatic send_req(input bdq_pkg::t_op op, input bdq_pkg::t_value value,
                            input bit fixed, input t_reply typed);
        int unsigned gap;
        t_reply      pred;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.op    <= op;
        req_ch.value <= value;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        pred = deque_apply(op, value);
        pending_replies.push_back(fixed ? typed : pred);
        items_sent++;
    endtask

    task automatic check_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual status %0d pos %0d count %0d",
                         $time, rsp_ch.status, rsp_ch.position, rsp_ch.entry_count);
                mismatches++;
            end else begin
                check_field("status", pending_replies[0].status, rsp_ch.status);
                check_field("position", pending_replies[0].position, rsp_ch.position);
                check_field("entry_count", pending_replies[0].entry_count, rsp_ch.entry_count);
                void'(pending_replies.pop_front());
            end
        end
    end

    initial begin
        int unsigned n;
        rsp_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            n = pick_gap();
            @(negedge i_clk);
            if (n != 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (n) @(negedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(0, 20)) @(negedge i_clk);
        end
    end

    initial begin
        t_reply          typed;
        t_mode           mode;
        bdq_pkg::t_op    op;
        bdq_pkg::t_value value;
        int              burst;

        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.op    = bdq_pkg::OP_COUNT;
        req_ch.value = '0;
        head_slot    = '0;
        held         = '0;
        mismatches   = 0;
        items_sent   = 0;
        quiet        = 1'b0;

        dir_rows = '{
            '{bdq_pkg::OP_COUNT,      32'sh0000_0000, 1'b1, bdq_pkg::ST_DONE,      7'd0, 7'd0},
            '{bdq_pkg::OP_POP_FRONT,  32'sh0000_0000, 1'b1, bdq_pkg::ST_EMPTY,     7'd0, 7'd0},
            '{bdq_pkg::OP_POP_BACK,   32'shFFFF_FFFF, 1'b1, bdq_pkg::ST_EMPTY,     7'd0, 7'd0},
            '{bdq_pkg::OP_SEARCH,     32'sh0000_0000, 1'b1, bdq_pkg::ST_NOT_FOUND, 7'd0, 7'd0},
            '{OP_UNUSED_6,            32'shFFFF_FFFF, 1'b1, bdq_pkg::ST_DONE,      7'd0, 7'd0},
            '{OP_UNUSED_7,            32'sh0000_0000, 1'b1, bdq_pkg::ST_DONE,      7'd0, 7'd0},
            '{bdq_pkg::OP_PUSH_BACK,  32'sh7FFF_FFFF, 1'b1, bdq_pkg::ST_DONE,      7'd0, 7'd1},
            '{bdq_pkg::OP_PUSH_FRONT, 32'sh8000_0000, 1'b1, bdq_pkg::ST_DONE,      7'd0, 7'd2},
            '{bdq_pkg::OP_PUSH_BACK,  32'shFFFF_FFFF, 1'b1, bdq_pkg::ST_DONE,      7'd0, 7'd3},
            '{bdq_pkg::OP_PUSH_FRONT, 32'sh0000_0000, 1'b1, bdq_pkg::ST_DONE,      7'd0, 7'd4},
            '{bdq_pkg::OP_SEARCH,     32'sh0000_0000, 1'b1, bdq_pkg::ST_DONE,      7'd1, 7'd4},
            '{bdq_pkg::OP_SEARCH,     32'shFFFF_FFFF, 1'b1, bdq_pkg::ST_DONE,      7'd4, 7'd4},
            '{bdq_pkg::OP_SEARCH,     32'sh8000_0000, 1'b0, bdq_pkg::ST_DONE,      7'd0, 7'd0},
            '{bdq_pkg::OP_SEARCH,     32'sh0000_0001, 1'b1, bdq_pkg::ST_NOT_FOUND, 7'd0, 7'd4},
            '{bdq_pkg::OP_PUSH_BACK,  32'sh0000_0000, 1'b1, bdq_pkg::ST_DONE,      7'd0, 7'd5},
            '{bdq_pkg::OP_SEARCH,     32'sh0000_0000, 1'b1, bdq_pkg::ST_DONE,      7'd1, 7'd5},
            '{bdq_pkg::OP_POP_FRONT,  32'sh1234_5678, 1'b1, bdq_pkg::ST_DONE,      7'd0, 7'd4},
            '{bdq_pkg::OP_SEARCH,     32'sh0000_0000, 1'b0, bdq_pkg::ST_DONE,      7'd0, 7'd0},
            '{bdq_pkg::OP_POP_BACK,   32'sh0000_0000, 1'b1, bdq_pkg::ST_DONE,      7'd0, 7'd3},
            '{bdq_pkg::OP_COUNT,      32'shFFFF_FFFF, 1'b1, bdq_pkg::ST_DONE,      7'd0, 7'd3},
            '{OP_UNUSED_6,            32'sh0000_0005, 1'b1, bdq_pkg::ST_DONE,      7'd0, 7'd3},
            '{bdq_pkg::OP_POP_BACK,   32'sh0000_0000, 1'b1, bdq_pkg::ST_DONE,      7'd0, 7'd2},
            '{bdq_pkg::OP_POP_BACK,   32'sh0000_0000, 1'b1, bdq_pkg::ST_DONE,      7'd0, 7'd1},
            '{bdq_pkg::OP_POP_BACK,   32'sh0000_0000, 1'b1, bdq_pkg::ST_DONE,      7'd0, 7'd0},
            '{bdq_pkg::OP_POP_FRONT,  32'sh0000_0000, 1'b1, bdq_pkg::ST_EMPTY,     7'd0, 7'd0}
        };

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            typed = '{dir_rows[i].status, dir_rows[i].position, dir_rows[i].entry_count};
            send_req(dir_rows[i].op, dir_rows[i].value, dir_rows[i].fixed, typed);
        end

        mode = MODE_FILL;
        while (items_sent < ITEM_TARGET) begin
            quiet = ($urandom_range(0, 3) == 0);
            case (mode)
                MODE_FILL, MODE_DRAIN: burst = 80;
                MODE_SEARCH:           burst = 30;
                default:               burst = 40;
            endcase
            repeat (burst) begin
                op    = pick_op(mode);
                value = (op == bdq_pkg::OP_SEARCH) ? pick_search_value() : pick_value();
                send_req(op, value, 1'b0, '0);
            end
            mode = (mode == MODE_DRAIN) ? MODE_FILL : t_mode'(mode + 1);
        end
        quiet = 1'b0;

        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/bdq_pkg.sv
hw/rtl/bdq_if.sv
hw/rtl/bdq_store.sv
hw/rtl/bounded_deque_with_search_unit.sv
bench/tb_top.sv
